/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the log-space ALU design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lpa_pkg.sv */
// ----------------------------------------------------------------------------
// Log-space ALU package
// Widths, operation and status codes, and the correction table builders.
// ----------------------------------------------------------------------------
package lpa_pkg;

  localparam int VAL_W         = 24;
  localparam int CUTOFF_W      = 23;
  localparam int FRACTION_BITS = 16;
  localparam int TABLE_DEPTH   = 1024;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  // Table step is 1/64, so the index drops FRACTION_BITS-6 fraction bits.
  localparam int IDX_SHIFT     = FRACTION_BITS - 6;
  // Corrections stay below 8 in magnitude: three integer bits and a sign.
  localparam int CORR_W        = FRACTION_BITS + 4;
  localparam int WIDE_W        = VAL_W + 2;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(2972806);

  localparam logic signed [WIDE_W-1:0] VAL_MAX = WIDE_W'(8388607);
  localparam logic signed [WIDE_W-1:0] VAL_MIN = -WIDE_W'(8388608);

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NEG_DIFF  = 2'd1,
    STAT_LOG_ZERO  = 2'd2,
    STAT_SATURATED = 2'd3
  } status_t;

  typedef logic signed [CORR_W-1:0] corr_t;
  typedef corr_t corr_table_t [TABLE_DEPTH];

  // Lookup request from the difference stage to the correction ROM.
  typedef struct packed {
    logic              en;
    logic              sub;
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } rom_req_t;

  localparam logic [63:0] Q_ONE = 64'd1 << 60;

  // (a*b) >> 60 on unsigned Q60 values, built from 32-bit partial products.
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] m, al, ah, bl, bh, t, w0, k, w1, w2, hi, lo;
    m  = 64'hFFFF_FFFF;
    al = a & m;
    ah = a >> 32;
    bl = b & m;
    bh = b >> 32;
    t  = al * bl;
    w0 = t & m;
    k  = t >> 32;
    t  = ah * bl + k;
    w1 = t & m;
    w2 = t >> 32;
    t  = al * bh + w1;
    k  = t >> 32;
    hi = ah * bh + w2 + k;
    lo = (t << 32) + w0;
    return (hi << 4) | (lo >> 60);
  endfunction

  // Restoring long division, used only while building the tables.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Fractional log2 of m in [1,2), Q60 in and out, by repeated squaring.
  function automatic logic [63:0] log2_frac(input logic [63:0] m_in);
    logic [63:0] m, r;
    m = m_in;
    r = '0;
    for (int i = 1; i <= 60; i++) begin
      m = qmul(m, m);
      if (m >= (Q_ONE << 1)) begin
        m = m >> 1;
        r = r | (64'd1 << (60 - i));
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] round_q60(input logic [63:0] mag);
    return (mag + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS);
  endfunction

  // Builds log(1+exp(-x)) when sub is 0, log(1-exp(-x)) when sub is 1, at
  // x = (idx+0.5)/64 for every entry.
  function automatic corr_table_t build_table(input logic sub);
    corr_table_t tbl;
    logic [63:0] ln2, q, term, step, p, v, mag, r;
    int          sh;
    ln2  = '0;
    q    = Q_ONE;
    term = Q_ONE;
    for (int k = 1; k <= 62; k++) begin
      ln2 = ln2 + udiv64(Q_ONE >> k, 64'(k));
    end
    for (int k = 1; k <= 14; k++) begin
      term = udiv64(term >> 7, 64'(k));
      if (k % 2 == 1) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    step = qmul(q, q);
    p    = q;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!sub) begin
        r      = round_q60(qmul(log2_frac(Q_ONE + p), ln2));
        tbl[i] = CORR_W'(r);
      end else begin
        v  = Q_ONE - p;
        sh = 0;
        for (int j = 0; j < 64; j++) begin
          if (v != 0 && v < Q_ONE) begin
            v  = v << 1;
            sh = sh + 1;
          end
        end
        if (v == 0) begin
          v = Q_ONE;
        end
        mag    = (64'(sh) << 60) - log2_frac(v);
        r      = round_q60(qmul(mag, ln2));
        tbl[i] = CORR_W'(64'd0 - r);
      end
      p = qmul(p, step);
    end
    return tbl;
  endfunction

endpackage

/* design/lpa_corr_rom.sv */
// ----------------------------------------------------------------------------
// Correction ROM
// Constant log1p(exp(-d)) and log1p(-exp(-d)) tables with a registered read.
// ----------------------------------------------------------------------------
module lpa_corr_rom (
  input  logic             clk,
  input  lpa_pkg::rom_req_t req,
  output lpa_pkg::corr_t   rd_corr
);
  import lpa_pkg::*;

  localparam corr_table_t ADD_TABLE = build_table(1'b0);
  localparam corr_table_t SUB_TABLE = build_table(1'b1);

  corr_t corr_r;
  corr_t corr_nxt;

  // Differences past the cutoff or past the table end read as zero.
  always_comb begin
    if (!req.hit) begin
      corr_nxt = '0;
    end else if (req.sub) begin
      corr_nxt = SUB_TABLE[req.addr];
    end else begin
      corr_nxt = ADD_TABLE[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      corr_r <= corr_nxt;
    end
  end

  assign rd_corr = corr_r;

endmodule

/* design/log_domain_probability_alu.sv */
// ----------------------------------------------------------------------------
// Log-domain probability ALU
// Multiply, divide, add and subtract on signed Q7.16 log-probabilities.
// ----------------------------------------------------------------------------
// The unit takes one operand transfer per clock while the output side is
// ready or a stage is empty, and returns one result per transfer, in order,
// from its output register. It is a three-stage pipeline: the first stage orders the
// operands, forms their difference and the plain sum or difference used by
// multiply and divide; the second stage compares the difference against the
// cutoff register and reads the correction ROM, whose registered read sets
// the stage boundary; the third stage adds the correction, handles the
// subtract special cases and saturates into the output register. Each stage
// carries its own valid bit and is reloaded whenever it is empty or its
// successor moves, so bubbles close up and a stalled output holds every item
// in place. The cutoff register is written through the cfg port, which is
// always ready; it should be written only while no item is in flight. There
// is no initialization sequence after reset: the ROM contents are constant.
`include "assert_macros.svh"

module log_domain_probability_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lpa_pkg::op_t                        in_operation,
  input  logic signed [lpa_pkg::VAL_W-1:0]    in_operand_a,
  input  logic signed [lpa_pkg::VAL_W-1:0]    in_operand_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lpa_pkg::VAL_W-1:0]    out_result_value,
  output lpa_pkg::status_t                    out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpa_pkg::CUTOFF_W-1:0]        cfg_cutoff
);
  import lpa_pkg::*;

  // Configuration register.
  logic [CUTOFF_W-1:0] cutoff_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cutoff_r <= cfg_cutoff;
    end
  end

  // Stage enables. A stage loads when it is empty or its content moves on.
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: operand ordering and difference.
  logic signed [VAL_W:0]   a_ext, b_ext;
  logic signed [VAL_W:0]   hi0, lo0, arith0, span0;
  logic                    a_gt_b0;

  always_comb begin
    a_ext   = (VAL_W+1)'(in_operand_a);
    b_ext   = (VAL_W+1)'(in_operand_b);
    a_gt_b0 = a_ext > b_ext;
    hi0     = a_gt_b0 ? a_ext : b_ext;
    lo0     = a_gt_b0 ? b_ext : a_ext;
    span0   = hi0 - lo0;
    if (in_operation == OP_MUL) begin
      arith0 = a_ext + b_ext;
    end else begin
      arith0 = a_ext - b_ext;
    end
  end

  op_t                     op1_r;
  logic signed [VAL_W-1:0] base1_r;
  logic [VAL_W-1:0]        diff1_r;
  logic signed [VAL_W:0]   arith1_r;
  logic                    b_gt_a1_r, eq1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r     <= in_operation;
      base1_r   <= VAL_W'(hi0);
      // The difference of two 24-bit values is non-negative here and fits.
      diff1_r   <= VAL_W'(span0);
      arith1_r  <= arith0;
      b_gt_a1_r <= b_ext > a_ext;
      eq1_r     <= a_ext == b_ext;
    end
  end

  // Stage 2: cutoff check and ROM lookup.
  logic [VAL_W-1:0] idx1;
  logic             in_table1;
  rom_req_t         rom_req;
  corr_t            corr2;

  always_comb begin
    idx1          = diff1_r >> IDX_SHIFT;
    in_table1     = 32'(idx1) < 32'(TABLE_DEPTH);
    rom_req.en    = en2;
    rom_req.sub   = op1_r == OP_SUB;
    rom_req.hit   = in_table1 && (diff1_r <= VAL_W'(cutoff_r));
    rom_req.addr  = ADDR_W'(idx1);
  end

  lpa_corr_rom u_corr_rom (
    .clk     (clk),
    .req     (rom_req),
    .rd_corr (corr2)
  );

  op_t                     op2_r;
  logic signed [VAL_W-1:0] base2_r;
  logic signed [VAL_W:0]   arith2_r;
  logic                    b_gt_a2_r, eq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2_r     <= op1_r;
      base2_r   <= base1_r;
      arith2_r  <= arith1_r;
      b_gt_a2_r <= b_gt_a1_r;
      eq2_r     <= eq1_r;
    end
  end

  // Stage 3: correction add, subtract special cases and saturation.
  logic signed [WIDE_W-1:0] sum2;
  logic signed [VAL_W-1:0]  res_nxt;
  status_t                  st_nxt;

  always_comb begin
    sum2    = WIDE_W'(arith2_r);
    res_nxt = '0;
    st_nxt  = STAT_OK;
    case (op2_r)
      OP_ADD: sum2 = WIDE_W'(base2_r) + WIDE_W'(corr2);
      OP_SUB: begin
        if (b_gt_a2_r) begin
          sum2   = VAL_MIN;
          st_nxt = STAT_NEG_DIFF;
        end else if (eq2_r) begin
          // The difference of a probability from itself is zero.
          sum2   = VAL_MIN;
          st_nxt = STAT_LOG_ZERO;
        end else begin
          sum2 = WIDE_W'(base2_r) + WIDE_W'(corr2);
        end
      end
      default: sum2 = WIDE_W'(arith2_r);
    endcase
    if (sum2 > VAL_MAX) begin
      res_nxt = VAL_W'(VAL_MAX);
      st_nxt  = STAT_SATURATED;
    end else if (sum2 < VAL_MIN) begin
      res_nxt = VAL_W'(VAL_MIN);
      st_nxt  = STAT_SATURATED;
    end else begin
      res_nxt = VAL_W'(sum2);
    end
  end

  logic signed [VAL_W-1:0] res3_r;
  status_t                 st3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res3_r <= res_nxt;
      st3_r  <= st_nxt;
    end
  end

  assign out_valid        = v3_r;
  assign out_result_value = res3_r;
  assign out_status       = st3_r;

  // Checks on the pipeline and the result encoding.
  `ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_ready_with_room, !(v1_r && v2_r && v3_r) |-> in_ready, "input stalled with room in the pipeline")
  `ASSERT_CLK(a_special_min, out_valid && (out_status == STAT_NEG_DIFF || out_status == STAT_LOG_ZERO) |-> out_result_value == VAL_W'(VAL_MIN), "subtract special case without minimum value")
  `ASSERT_CLK(a_saturated_bound, out_valid && out_status == STAT_SATURATED |-> out_result_value == VAL_W'(VAL_MAX) || out_result_value == VAL_W'(VAL_MIN), "saturated status off the range bounds")

endmodule
